// File: rtl/core/mpv_pkg.sv
// package: payload types, sha-512 constants and round functions
`timescale 1ns / 1ps
`default_nettype none
package mpv_pkg;

  localparam int unsigned BirthdayBitsDef = 50;
  localparam logic [31:0] NonceLimitDef   = 32'd67108864;
  localparam int unsigned OutBits         = 50;
  localparam int unsigned Rounds          = 80;
  localparam int unsigned NoncesPerDigest = 8;
  localparam int unsigned SelBits         = $clog2(NoncesPerDigest);

  typedef struct packed {
    logic [63:0] mid_hash_w0;
    logic [63:0] mid_hash_w1;
    logic [63:0] mid_hash_w2;
    logic [63:0] mid_hash_w3;
    logic [31:0] nonce_a;
    logic [31:0] nonce_b;
  } in_t;

  typedef struct packed {
    logic              proof_valid;
    logic [OutBits-1:0] birthday_a;
    logic [OutBits-1:0] birthday_b;
  } out_t;

  // working variables a..h
  typedef logic [7:0][63:0] state_t;
  // message schedule window, entry 0 is w[i]
  typedef logic [15:0][63:0] sched_t;

  localparam logic [63:0] K512 [Rounds] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  localparam state_t IV512 = {
    64'h5be0cd19137e2179, 64'h1f83d9abfb41bd6b, 64'h9b05688c2b3e6c1f, 64'h510e527fade682d1,
    64'ha54ff53a5f1d36f1, 64'h3c6ef372fe94f82b, 64'hbb67ae8584caa73b, 64'h6a09e667f3bcc908
  };

  function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (64 - n));
  endfunction

  function automatic logic [63:0] bswap(input logic [63:0] x);
    logic [63:0] r;
    for (int i = 0; i < 8; i++) r[8*i +: 8] = x[8*(7-i) +: 8];
    bswap = r;
  endfunction

  // one compression round; entry 0 is a, entry 7 is h
  function automatic state_t round_fn(input state_t s, input logic [63:0] kw);
    logic [63:0] t1;
    logic [63:0] t2;
    state_t      r;
    t1 = s[7] + (rotr(s[4], 14) ^ rotr(s[4], 18) ^ rotr(s[4], 41))
         + ((s[4] & s[5]) ^ (~s[4] & s[6])) + kw;
    t2 = (rotr(s[0], 28) ^ rotr(s[0], 34) ^ rotr(s[0], 39))
         + ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
    r[7] = s[6]; r[6] = s[5]; r[5] = s[4]; r[4] = s[3] + t1;
    r[3] = s[2]; r[2] = s[1]; r[1] = s[0]; r[0] = t1 + t2;
    round_fn = r;
  endfunction

  // slide schedule window by one word
  function automatic sched_t sched_fn(input sched_t w);
    logic [63:0] s0;
    logic [63:0] s1;
    sched_t      r;
    s0 = rotr(w[1], 1) ^ rotr(w[1], 8) ^ (w[1] >> 7);
    s1 = rotr(w[14], 19) ^ rotr(w[14], 61) ^ (w[14] >> 6);
    for (int i = 0; i < 15; i++) r[i] = w[i+1];
    r[15] = w[0] + s0 + w[9] + s1;
    sched_fn = r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/momentum_pow_verify.sv
// path from request accept to result valid: stage 0 register, round stages, birthday register, output register
// throughput: one nonce pair per cycle while the output is not stalled; 80 sha-512 rounds, one round per pipeline stage
// both nonces hash in two parallel round pipelines; the whole pipe stalls together
// when the output holds an untaken result
// reset clears valid bits only; datapath registers are not reset
`timescale 1ns / 1ps
`default_nettype none
module momentum_pow_verify #(
  parameter int unsigned BIRTHDAY_BITS = mpv_pkg::BirthdayBitsDef,
  parameter logic [31:0] NONCE_LIMIT   = mpv_pkg::NonceLimitDef
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire mpv_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output mpv_pkg::out_t      out_data
);

  localparam int unsigned Lat = mpv_pkg::Rounds + 2;

  logic                     en;
  logic [Lat-1:0]           vld;
  logic [255:0]             mid;
  logic [BIRTHDAY_BITS-1:0] bda;
  logic [BIRTHDAY_BITS-1:0] bdb;
  logic                     ok   [Lat];

  // pipeline advances whenever the output slot is free or being taken
  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign mid      = {in_data.mid_hash_w3, in_data.mid_hash_w2,
                     in_data.mid_hash_w1, in_data.mid_hash_w0};

  mpv_sha_pipe #(.BIRTHDAY_BITS(BIRTHDAY_BITS)) u_sha_a (
    .clk(clk), .en(en), .mid(mid), .nonce(in_data.nonce_a), .birthday(bda)
  );
  mpv_sha_pipe #(.BIRTHDAY_BITS(BIRTHDAY_BITS)) u_sha_b (
    .clk(clk), .en(en), .mid(mid), .nonce(in_data.nonce_b), .birthday(bdb)
  );

  // nonce checks travel with the item
  always_ff @(posedge clk) begin
    if (en) begin
      ok[0] <= (in_data.nonce_a != in_data.nonce_b) && (in_data.nonce_a <= NONCE_LIMIT)
               && (in_data.nonce_b <= NONCE_LIMIT);
      for (int i = 1; i < Lat; i++) ok[i] <= ok[i-1];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Lat-2:0], in_valid};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[Lat-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.proof_valid <= ok[Lat-1] && (bda == bdb);
      out_data.birthday_a  <= mpv_pkg::OutBits'({{64{1'b0}}, bda});
      out_data.birthday_b  <= mpv_pkg::OutBits'({{64{1'b0}}, bdb});
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/mpv_sha_pipe.sv
// fully unrolled sha-512 pipeline, one round per stage, birthday extraction at the end
`timescale 1ns / 1ps
`default_nettype none
module mpv_sha_pipe #(
  parameter int unsigned BIRTHDAY_BITS = mpv_pkg::BirthdayBitsDef
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [255:0]             mid,
  input  wire logic [31:0]              nonce,
  output logic      [BIRTHDAY_BITS-1:0] birthday
);

  localparam int unsigned R = mpv_pkg::Rounds;

  mpv_pkg::state_t                  st  [R+1];
  mpv_pkg::sched_t                  ws  [R+1];
  logic [mpv_pkg::SelBits-1:0]      sel [R+1];
  logic [63:0]                      kw  [R+1];
  logic [63:0]                      word;
  mpv_pkg::sched_t                  blk;
  logic [31:0]                      base;
  logic [287:0]                     msg;

  // build the padded block: base nonce le, mid bytes, pad, length 288
  always_comb begin
    base = {nonce[31:mpv_pkg::SelBits], {mpv_pkg::SelBits{1'b0}}};
    msg  = {mid, base};
    blk  = '0;
    for (int b = 0; b < 36; b++) blk[b/8][8*(7-(b%8)) +: 8] = msg[8*b +: 8];
    blk[4][31:24] = 8'h80;
    blk[15][15:0] = 16'h0120;
  end

  // stage 0 holds the block and the precomputed k+w
  always_ff @(posedge clk) begin
    if (en) begin
      st[0]  <= mpv_pkg::IV512;
      ws[0]  <= blk;
      kw[0]  <= mpv_pkg::K512[0] + blk[0];
      sel[0] <= nonce[mpv_pkg::SelBits-1:0];
    end
  end

  // one round per stage, schedule advances alongside
  for (genvar i = 0; i < R; i++) begin : g_round
    mpv_pkg::sched_t nx;
    assign nx = mpv_pkg::sched_fn(ws[i]);
    always_ff @(posedge clk) begin
      if (en) begin
        st[i+1]  <= mpv_pkg::round_fn(st[i], kw[i]);
        ws[i+1]  <= nx;
        kw[i+1]  <= (i + 1 < R) ? mpv_pkg::K512[(i+1) % R] + nx[0] : '0;
        sel[i+1] <= sel[i];
      end
    end
  end

  // final add of the chosen word and birthday
  always_comb begin
    word = mpv_pkg::IV512[sel[R]] + st[R][sel[R]];
  end

  always_ff @(posedge clk) begin
    if (en) birthday <= BIRTHDAY_BITS'(mpv_pkg::bswap(word) >> (64 - BIRTHDAY_BITS));
  end

endmodule
`default_nettype wire

// File: rtl/core/mpv_checker.sv
// port-level checker for the verifier, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module mpv_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          in_ready,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire mpv_pkg::out_t out_data
);

  // result held while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // ready follows the output slot
  a_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while output blocked");

  // equal birthdays are needed for a valid proof
  a_match: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.proof_valid |-> out_data.birthday_a == out_data.birthday_b)
    else $error("valid proof with differing birthdays");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");

endmodule

bind momentum_pow_verify mpv_checker u_mpv_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire
